[rtl/core/message_sampler_rate_limit_defines.svh]
// Assertion macros shared by the message sampler RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MESSAGE_SAMPLER_RATE_LIMIT_DEFINES_SVH
`define MESSAGE_SAMPLER_RATE_LIMIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSRL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/msrl_pkg.sv]
// Types, codes and the LCG step function for the message sampler.
// Depends on nothing; used by every module of the block.
package msrl_pkg;

  localparam int unsigned LcgWidth  = 48;
  localparam int unsigned ProbWidth = 49;
  localparam int unsigned CountWidth = 32;

  localparam logic [34:0] LcgMult = 35'h5DEECE66D;
  localparam logic [47:0] LcgAdd  = 48'hB;

  typedef enum logic [2:0] {
    CfgSampleMode     = 3'd0,
    CfgEveryK         = 3'd1,
    CfgPassProbability = 3'd2,
    CfgMinPerSecond   = 3'd3,
    CfgMaxPerSecond   = 3'd4,
    CfgGeneratorSeed  = 3'd5,
    CfgCountStart     = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    ReasonBelowMin    = 2'd0,
    ReasonSampled     = 2'd1,
    ReasonNotSampled  = 2'd2,
    ReasonOverMax     = 2'd3
  } reason_t;

  typedef struct packed {
    logic                   sample_mode;
    logic [CountWidth-1:0]  every_k;
    logic [ProbWidth-1:0]   pass_probability;
    logic [CountWidth-1:0]  min_per_second;
    logic [CountWidth-1:0]  max_per_second;
  } cfg_t;

  typedef struct packed {
    logic    verdict;
    reason_t reason;
  } result_t;

  // One LCG step modulo 2^48, split so that no partial product exceeds 24x35.
  function automatic logic [LcgWidth-1:0] lcg_advance(input logic [LcgWidth-1:0] x);
    logic [58:0] prod_lo;
    logic [47:0] prod_hi;
    prod_lo = 59'(x[23:0]) * 59'(LcgMult);
    prod_hi = 48'(x[47:24]) * 48'(LcgMult[23:0]);
    return prod_lo[47:0] + {prod_hi[23:0], 24'd0} + LcgAdd;
  endfunction

endpackage

[rtl/core/msrl_lcg.sv]
// Random draw generator: holds the LCG state and its precomputed successor.
// Depends on msrl_pkg and the assertion macro header.
`include "message_sampler_rate_limit_defines.svh"

module msrl_lcg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          seed_load,
  input  logic [msrl_pkg::LcgWidth-1:0] seed_value,
  input  logic                          draw_take,
  output logic [msrl_pkg::LcgWidth-1:0] draw
);

  logic [msrl_pkg::LcgWidth-1:0] lcg_state;
  logic [msrl_pkg::LcgWidth-1:0] lcg_ahead;
  logic [msrl_pkg::LcgWidth-1:0] mult_in;

  // The state's successor is precomputed; a seed load makes it stale.
  assign mult_in = draw_take ? lcg_ahead : lcg_state;
  assign draw    = lcg_ahead;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= '0;
    end else if (seed_load) begin
      lcg_state <= seed_value;
    end else if (draw_take) begin
      lcg_state <= lcg_ahead;
    end
  end

  always_ff @(posedge clk) begin
    lcg_ahead <= msrl_pkg::lcg_advance(mult_in);
  end

  `MSRL_ASSERT_NEXT(a_draw_advances, clk, rst, draw_take && !seed_load, lcg_state == $past(lcg_ahead), "LCG state did not advance to the drawn value")

endmodule

[rtl/core/msrl_decide.sv]
// Per-second window, minimum pass, count or random sampling and maximum throttle.
// Depends on msrl_pkg and the assertion macro header.
`include "message_sampler_rate_limit_defines.svh"

module msrl_decide (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic [msrl_pkg::CountWidth-1:0] now_seconds,
  input  msrl_pkg::cfg_t                  cfg,
  input  logic                            count_load,
  input  logic [msrl_pkg::CountWidth-1:0] count_value,
  input  logic [msrl_pkg::LcgWidth-1:0]   draw,
  output logic                            draw_take,
  output msrl_pkg::result_t               result
);

  logic [msrl_pkg::CountWidth-1:0] window_second;
  logic [msrl_pkg::CountWidth-1:0] win_accepts;
  logic [msrl_pkg::CountWidth-1:0] win_accepts_next;
  logic [msrl_pkg::CountWidth-1:0] phase_counter;
  logic [msrl_pkg::CountWidth-1:0] phase_counter_next;

  logic                            new_window;
  logic [msrl_pkg::CountWidth-1:0] acc_cur;
  logic [msrl_pkg::CountWidth:0]   phase_inc;
  logic                            below_min;
  logic                            sampled;
  logic                            over_max;
  logic                            counted;

  always_comb begin
    new_window = now_seconds != window_second;
    acc_cur    = new_window ? '0 : win_accepts;
    below_min  = (cfg.min_per_second != '0) && (acc_cur < cfg.min_per_second);
    phase_inc  = {1'b0, phase_counter} + (msrl_pkg::CountWidth+1)'(1);
    if (cfg.sample_mode) begin
      sampled = {1'b0, draw} < cfg.pass_probability;
    end else begin
      sampled = phase_inc >= {1'b0, cfg.every_k};
    end
    over_max  = (cfg.max_per_second != '0) && (acc_cur >= cfg.max_per_second);
    counted   = below_min || (sampled && !over_max);
    draw_take = take && cfg.sample_mode && !below_min;

    if (counted && (acc_cur != '1)) begin
      win_accepts_next = acc_cur + msrl_pkg::CountWidth'(1);
    end else begin
      win_accepts_next = acc_cur;
    end

    phase_counter_next = phase_counter;
    if (!cfg.sample_mode && !below_min) begin
      phase_counter_next = sampled ? '0 : phase_inc[msrl_pkg::CountWidth-1:0];
    end

    if (below_min) begin
      result.verdict = 1'b0;
      result.reason  = msrl_pkg::ReasonBelowMin;
    end else if (!sampled) begin
      result.verdict = 1'b1;
      result.reason  = msrl_pkg::ReasonNotSampled;
    end else if (over_max) begin
      result.verdict = 1'b1;
      result.reason  = msrl_pkg::ReasonOverMax;
    end else begin
      result.verdict = 1'b0;
      result.reason  = msrl_pkg::ReasonSampled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_second <= '0;
      win_accepts   <= '0;
      phase_counter <= '0;
    end else begin
      if (take) begin
        window_second <= now_seconds;
        win_accepts   <= win_accepts_next;
      end
      if (count_load) begin
        phase_counter <= count_value;
      end else if (take) begin
        phase_counter <= phase_counter_next;
      end
    end
  end

  `MSRL_ASSERT_SAME(a_over_needs_max, clk, rst, take && result.reason == msrl_pkg::ReasonOverMax, cfg.max_per_second != '0, "Throttled without a maximum")
  `MSRL_ASSERT_NEXT(a_count_monotonic, clk, rst, take && !new_window, win_accepts >= $past(win_accepts), "Accepted count fell within a window")

endmodule

[rtl/core/message_sampler_rate_limit.sv]
// Message sampler with per-second minimum and maximum: top level.
// Depends on msrl_pkg, msrl_lcg, msrl_decide and the assertion macro header.
// The input is registered; its result is then registered into m_tdata when the output is free.
// Throughput: one message per cycle unless the output stalls; the LCG successor is precomputed.
// Reset (rst, synchronous): the configuration takes its defaults, window and counts clear.
// After reset or a seed write the draw lookahead is stale until recomputed from the new state.
`include "message_sampler_rate_limit_defines.svh"

module message_sampler_rate_limit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] now_seconds
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [0] verdict, [2:1] reason, [7:3] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [48:0] cfg_data
);

  msrl_pkg::cfg_t    cfg;
  msrl_pkg::result_t result;

  logic                            in_valid;
  logic [msrl_pkg::CountWidth-1:0] in_now;
  logic                            advance;
  logic                            cfg_write;
  logic                            seed_load;
  logic                            count_load;
  logic                            draw_take;
  logic [msrl_pkg::LcgWidth-1:0]   draw;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign seed_load  = cfg_write && (cfg_index == msrl_pkg::CfgGeneratorSeed);
  assign count_load = cfg_write && (cfg_index == msrl_pkg::CfgCountStart);

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_mode      <= 1'b0;
      cfg.every_k          <= msrl_pkg::CountWidth'(1);
      cfg.pass_probability <= {1'b1, {msrl_pkg::LcgWidth{1'b0}}};
      cfg.min_per_second   <= '0;
      cfg.max_per_second   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        msrl_pkg::CfgSampleMode:      cfg.sample_mode      <= cfg_data[0];
        msrl_pkg::CfgEveryK:          cfg.every_k          <= cfg_data[31:0];
        msrl_pkg::CfgPassProbability: cfg.pass_probability <= cfg_data;
        msrl_pkg::CfgMinPerSecond:    cfg.min_per_second   <= cfg_data[31:0];
        msrl_pkg::CfgMaxPerSecond:    cfg.max_per_second   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'd0, result.reason, result.verdict};
    end
  end

  msrl_lcg u_lcg (
    .clk        (clk),
    .rst        (rst),
    .seed_load  (seed_load),
    .seed_value (cfg_data[msrl_pkg::LcgWidth-1:0]),
    .draw_take  (draw_take),
    .draw       (draw)
  );

  msrl_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .take        (advance),
    .now_seconds (in_now),
    .cfg         (cfg),
    .count_load  (count_load),
    .count_value (cfg_data[msrl_pkg::CountWidth-1:0]),
    .draw        (draw),
    .draw_take   (draw_take),
    .result      (result)
  );

  `MSRL_ASSERT_SAME(a_pass_reason, clk, rst, m_tvalid && !m_tdata[0], m_tdata[2:1] == msrl_pkg::ReasonBelowMin || m_tdata[2:1] == msrl_pkg::ReasonSampled, "Pass verdict with a drop reason")

endmodule

[tb/msrl_decision_checker.sv]
`timescale 1ns / 100ps
// Decision checker for the message sampler: watches the configuration, input and result
// channels, predicts each verdict and compares it. Depends on msrl_pkg.
module msrl_decision_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [48:0] cfg_data,
  output logic [31:0] failures,
  output logic [31:0] outstanding,
  output logic [31:0] n_below_min,
  output logic [31:0] n_sampled,
  output logic [31:0] n_not_sampled,
  output logic [31:0] n_over_max
);

  logic        random_mode;
  logic [31:0] period;
  logic [48:0] threshold;
  logic [31:0] min_pass;
  logic [31:0] max_pass;
  logic [31:0] window_sec;
  logic [31:0] taken;
  logic [31:0] phase;
  logic [47:0] lcg;

  msrl_pkg::result_t pending_decisions[$];
  int      fail_count = 0;
  int      tally[4];

  initial begin
    failures = '0;
    outstanding = '0;
    n_below_min = '0;
    n_sampled = '0;
    n_not_sampled = '0;
    n_over_max = '0;
    for (int i = 0; i < 4; i++) tally[i] = 0;
  end

  task automatic count_taken();
    if (taken != 32'hFFFF_FFFF) taken = taken + 32'd1;
  endtask

  task automatic apply_ceiling(output msrl_pkg::result_t r);
    if (max_pass != 0 && taken >= max_pass) begin
      r.verdict = 1'b1;
      r.reason = msrl_pkg::ReasonOverMax;
    end else begin
      count_taken();
      r.verdict = 1'b0;
      r.reason = msrl_pkg::ReasonSampled;
    end
  endtask

  task automatic decide_message(input logic [31:0] now, output msrl_pkg::result_t r);
    logic [32:0] nxt_phase;
    if (now != window_sec) begin
      window_sec = now;
      taken = '0;
    end
    r.verdict = 1'b1;
    r.reason = msrl_pkg::ReasonNotSampled;
    if (min_pass != 0 && taken < min_pass) begin
      count_taken();
      r.verdict = 1'b0;
      r.reason = msrl_pkg::ReasonBelowMin;
    end else if (!random_mode) begin
      nxt_phase = {1'b0, phase} + 33'd1;
      if (nxt_phase >= {1'b0, period}) begin
        phase = '0;
        apply_ceiling(r);
      end else begin
        phase = nxt_phase[31:0];
      end
    end else begin
      lcg = lcg * 48'h5_DEEC_E66D + 48'hB;
      if ({1'b0, lcg} < threshold) apply_ceiling(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input msrl_pkg::result_t want);
    if (fail_count < 60)
      $display("[%0t] mismatch, %s: got verdict %0b reason %0d pad %0h, want verdict %0b reason %0d",
               $time, what, got[0], got[2:1], got[7:3], want.verdict, want.reason);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin : watch
    msrl_pkg::result_t want;
    if (rst) begin
      random_mode = 1'b0;
      period = 32'd1;
      threshold = 49'h1_0000_0000_0000;
      min_pass = '0;
      max_pass = '0;
      window_sec = '0;
      taken = '0;
      phase = '0;
      lcg = '0;
      pending_decisions.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          msrl_pkg::CfgSampleMode:      random_mode = cfg_data[0];
          msrl_pkg::CfgEveryK:          period = cfg_data[31:0];
          msrl_pkg::CfgPassProbability: threshold = cfg_data;
          msrl_pkg::CfgMinPerSecond:    min_pass = cfg_data[31:0];
          msrl_pkg::CfgMaxPerSecond:    max_pass = cfg_data[31:0];
          msrl_pkg::CfgGeneratorSeed:   lcg = cfg_data[47:0];
          msrl_pkg::CfgCountStart:      phase = cfg_data[31:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        decide_message(s_tdata, want);
        pending_decisions.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (pending_decisions.size() == 0) begin
          want.verdict = 1'b0;
          want.reason = msrl_pkg::ReasonBelowMin;
          report_mismatch("result beat with nothing expected", m_tdata, want);
        end else begin
          want = pending_decisions.pop_front();
          if (m_tdata[0] !== want.verdict) report_mismatch("verdict", m_tdata, want);
          else if (m_tdata[2:1] !== want.reason) report_mismatch("reason", m_tdata, want);
          else if (m_tdata[7:3] !== 5'd0) report_mismatch("padding", m_tdata, want);
          tally[want.reason] = tally[want.reason] + 1;
        end
      end
    end
    failures <= fail_count;
    outstanding <= pending_decisions.size();
    n_below_min <= tally[msrl_pkg::ReasonBelowMin];
    n_sampled <= tally[msrl_pkg::ReasonSampled];
    n_not_sampled <= tally[msrl_pkg::ReasonNotSampled];
    n_over_max <= tally[msrl_pkg::ReasonOverMax];
  end

endmodule

[tb/tb_message_sampler_rate_limit.sv]
`timescale 1ns / 100ps
// Testbench top for message_sampler_rate_limit: clock, reset, register programming,
// message stimulus and the verdict. Depends on msrl_pkg and msrl_decision_checker.
module tb_message_sampler_rate_limit;

  localparam logic [2:0] UnusedIndex = 3'd7;
  localparam int StallLimit = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [48:0] cfg_data = '0;

  logic [31:0] failures;
  logic [31:0] outstanding;
  logic [31:0] n_below_min;
  logic [31:0] n_sampled;
  logic [31:0] n_not_sampled;
  logic [31:0] n_over_max;

  logic        calm = 1'b0;
  int          stall_cycles = 0;
  int          message_count = 0;
  int          settings_count = 0;
  logic [31:0] clock_sec = '0;
  logic [2:0]  write_index[$];
  logic [48:0] write_value[$];

  message_sampler_rate_limit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  msrl_decision_checker decision_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding),
    .n_below_min(n_below_min), .n_sampled(n_sampled),
    .n_not_sampled(n_not_sampled), .n_over_max(n_over_max)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [48:0] with_junk(input logic [48:0] v, input int width);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(1) == 1) return v | (junk[48:0] << width);
    return v;
  endfunction

  function automatic logic [47:0] random48();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[47:0];
  endfunction

  function automatic logic [31:0] next_second(input logic [31:0] cur);
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return cur;
    if (pick < 92) return cur + 32'd1;
    if (pick < 97) return $urandom;
    return ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  function automatic void queue_write(input logic [2:0] idx, input logic [48:0] val);
    write_index.push_back(idx);
    write_value.push_back(val);
  endfunction

  task automatic apply_writes();
    while (write_index.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_index <= write_index.pop_front();
      cfg_data <= write_value.pop_front();
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_count = settings_count + 1;
  endtask

  task automatic send_message(input logic [31:0] now);
    if (!calm && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= now;
    do @(posedge clk); while (!s_tready);
    message_count = message_count + 1;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_settings();
    logic [31:0] k;
    logic [48:0] prob;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [47:0] seed;
    logic [31:0] start;
    case ($urandom_range(5))
      0: k = 32'd0;
      1: k = 32'd1;
      2: k = 32'hFFFF_FFFF;
      default: k = $urandom_range(2, 7);
    endcase
    case ($urandom_range(4))
      0: prob = '0;
      1: prob = 49'h1_0000_0000_0000;
      2: prob = 49'h1_FFFF_FFFF_FFFF;
      default: prob = {1'b0, random48()};
    endcase
    case ($urandom_range(7))
      0, 1, 2: lo = '0;
      3, 4, 5: lo = $urandom_range(1, 3);
      6: lo = $urandom_range(4, 8);
      default: lo = $urandom;
    endcase
    case ($urandom_range(7))
      0, 1: hi = '0;
      6: hi = 32'hFFFF_FFFF;
      7: hi = $urandom;
      default: hi = $urandom_range(1, 6);
    endcase
    case ($urandom_range(3))
      0: seed = '0;
      1: seed = 48'hFFFF_FFFF_FFFF;
      default: seed = random48();
    endcase
    case ($urandom_range(4))
      0: start = '0;
      1: start = 32'hFFFF_FFFF;
      2: start = k + $urandom_range(0, 3);
      default: start = $urandom_range(0, 7);
    endcase
    queue_write(msrl_pkg::CfgSampleMode, with_junk(49'($urandom_range(1)), 1));
    queue_write(msrl_pkg::CfgEveryK, with_junk(49'(k), 32));
    queue_write(msrl_pkg::CfgPassProbability, prob);
    queue_write(msrl_pkg::CfgMinPerSecond, with_junk(49'(lo), 32));
    queue_write(msrl_pkg::CfgMaxPerSecond, with_junk(49'(hi), 32));
    queue_write(msrl_pkg::CfgGeneratorSeed, with_junk(49'(seed), 48));
    queue_write(msrl_pkg::CfgCountStart, with_junk(49'(start), 32));
    if ($urandom_range(3) == 0) queue_write(UnusedIndex, {1'b0, random48()});
  endtask

  task automatic random_phase(input int items, input bit drain_midway);
    for (int i = 0; i < items; i++) begin
      if (drain_midway && i == items / 2) drain();
      send_message(clock_sec);
      clock_sec = next_second(clock_sec);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_message(32'd0);
    send_message(32'd0);
    send_message(32'hFFFF_FFFF);
    drain();

    queue_write(msrl_pkg::CfgSampleMode, 49'h2);
    queue_write(msrl_pkg::CfgEveryK, 49'd3);
    queue_write(msrl_pkg::CfgPassProbability, 49'd0);
    queue_write(msrl_pkg::CfgMinPerSecond, 49'd2);
    queue_write(msrl_pkg::CfgMaxPerSecond, 49'd3);
    queue_write(msrl_pkg::CfgGeneratorSeed, 49'h0_FFFF_FFFF_FFFF);
    queue_write(msrl_pkg::CfgCountStart, 49'd0);
    queue_write(UnusedIndex, 49'h1_FFFF_FFFF_FFFF);
    apply_writes();
    repeat (8) send_message(32'd5);
    drain();

    queue_write(msrl_pkg::CfgEveryK, 49'd0);
    queue_write(msrl_pkg::CfgCountStart, 49'h1_FFFF_FFFF_FFFF);
    queue_write(msrl_pkg::CfgMinPerSecond, 49'd0);
    queue_write(msrl_pkg::CfgMaxPerSecond, 49'd0);
    apply_writes();
    repeat (2) send_message(32'd6);
    drain();

    queue_write(msrl_pkg::CfgEveryK, 49'd5);
    queue_write(msrl_pkg::CfgCountStart, 49'd9);
    apply_writes();
    repeat (2) send_message(32'd6);
    drain();

    queue_write(msrl_pkg::CfgSampleMode, 49'h3);
    queue_write(msrl_pkg::CfgPassProbability, 49'd0);
    apply_writes();
    repeat (3) send_message(32'd7);
    drain();

    queue_write(msrl_pkg::CfgPassProbability, 49'h1_FFFF_FFFF_FFFF);
    apply_writes();
    repeat (3) send_message(32'd7);
    drain();

    queue_write(msrl_pkg::CfgPassProbability, 49'h1_0000_0000_0000);
    queue_write(msrl_pkg::CfgGeneratorSeed, 49'd0);
    apply_writes();
    repeat (2) send_message(32'd8);
    drain();

    queue_write(msrl_pkg::CfgSampleMode, 49'd1);
    queue_write(msrl_pkg::CfgEveryK, 49'hFFFF_FFFF);
    queue_write(msrl_pkg::CfgPassProbability, 49'h1_FFFF_FFFF_FFFF);
    queue_write(msrl_pkg::CfgMinPerSecond, 49'hFFFF_FFFF);
    queue_write(msrl_pkg::CfgMaxPerSecond, 49'hFFFF_FFFF);
    queue_write(msrl_pkg::CfgGeneratorSeed, 49'h0_FFFF_FFFF_FFFF);
    queue_write(msrl_pkg::CfgCountStart, 49'hFFFF_FFFE);
    apply_writes();
    random_phase(60, 1'b0);

    queue_write(msrl_pkg::CfgSampleMode, 49'd0);
    queue_write(msrl_pkg::CfgEveryK, 49'd0);
    queue_write(msrl_pkg::CfgPassProbability, 49'd0);
    queue_write(msrl_pkg::CfgMinPerSecond, 49'd0);
    queue_write(msrl_pkg::CfgMaxPerSecond, 49'd0);
    queue_write(msrl_pkg::CfgGeneratorSeed, 49'd0);
    queue_write(msrl_pkg::CfgCountStart, 49'd0);
    apply_writes();
    random_phase(60, 1'b0);

    for (int p = 0; p < 10; p++) begin
      calm <= (p == 4);
      pick_settings();
      apply_writes();
      random_phase(183, p == 6);
    end
    calm <= 1'b0;

    drain();
    $display("Sent %0d messages under %0d register settings, random phases included.",
             message_count, settings_count);
    $display("Decisions: %0d below minimum, %0d sampled, %0d not sampled, %0d over maximum.",
             n_below_min, n_sampled, n_not_sampled, n_over_max);
    if (failures == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
